### hw/rtl/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared constants and types of the clipped line rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package clr_pkg;

   localparam int DISPLAY_WIDTH = 320;
   localparam int STRIP_ROWS    = 40;

   localparam int COORD_W = 12;
   localparam int SPAN_W  = COORD_W + 1;
   localparam int ERR_W   = COORD_W + 2;
   localparam int COLOR_W = 16;
   localparam int ADDR_W  = 14;

   // Full product width of row * DISPLAY_WIDTH + column before truncation
   localparam int PROD_W  = 2 * COORD_W + 2;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

   // Pixel produced for one word, before clipping
   typedef struct packed {
      logic                      blank;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COLOR_W-1:0]        color;
      logic                      done;
   } pixel_type;

endpackage

`default_nettype wire

### hw/rtl/clr_step.sv
// ----------------------------------------------------------------------------
// clr_step
// Line state and one Bresenham update per word; presents the resulting pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_step
   import clr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      fire,
   input  wire logic                      command,
   input  wire logic signed [COORD_W-1:0] start_x,
   input  wire logic signed [COORD_W-1:0] start_y,
   input  wire logic signed [COORD_W-1:0] end_x,
   input  wire logic signed [COORD_W-1:0] end_y,
   input  wire logic [COLOR_W-1:0]        pen_color,
   output pixel_type                      pixel
);

   logic signed [COORD_W-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_W-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_W-1:0] goal_x_ff, goal_x_in;
   logic signed [COORD_W-1:0] goal_y_ff, goal_y_in;
   logic [SPAN_W-1:0]         span_x_ff, span_x_in;
   logic signed [SPAN_W-1:0]  neg_span_y_ff, neg_span_y_in;
   logic                      step_right_ff, step_right_in;
   logic                      step_down_ff, step_down_in;
   logic signed [ERR_W-1:0]   error_ff, error_in;
   logic [COLOR_W-1:0]        color_ff, color_in;
   logic                      active_ff, active_in;

   logic signed [SPAN_W-1:0]  dx, dy;
   logic signed [ERR_W:0]     twice, sum;
   logic                      move_x, move_y, done;

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      span_x_in     = span_x_ff;
      neg_span_y_in = neg_span_y_ff;
      step_right_in = step_right_ff;
      step_down_in  = step_down_ff;
      error_in      = error_ff;
      color_in      = color_ff;
      active_in     = active_ff;
      dx     = SPAN_W'(end_x) - SPAN_W'(start_x);
      dy     = SPAN_W'(end_y) - SPAN_W'(start_y);
      twice  = (ERR_W+1)'(error_ff) <<< 1;
      move_x = twice >= (ERR_W+1)'(neg_span_y_ff);
      move_y = twice <= $signed({2'b00, span_x_ff});
      sum    = (ERR_W+1)'(error_ff);
      done   = 1'b1;

      if (command == CMD_START) begin
         cur_x_in      = start_x;
         cur_y_in      = start_y;
         goal_x_in     = end_x;
         goal_y_in     = end_y;
         color_in      = pen_color;
         span_x_in     = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
         neg_span_y_in = dy[SPAN_W-1] ? dy : -dy;
         step_right_in = start_x < end_x;
         step_down_in  = start_y < end_y;
         error_in      = ERR_W'({1'b0, span_x_in}) + ERR_W'(neg_span_y_in);
         done          = (start_x == end_x) && (start_y == end_y);
         active_in     = !done;
      end else if (active_ff) begin
         if (move_x) begin
            sum      = sum + (ERR_W+1)'(neg_span_y_ff);
            cur_x_in = step_right_ff ? cur_x_ff + COORD_W'(1) : cur_x_ff - COORD_W'(1);
         end
         if (move_y) begin
            sum      = sum + $signed({2'b00, span_x_ff});
            cur_y_in = step_down_ff ? cur_y_ff + COORD_W'(1) : cur_y_ff - COORD_W'(1);
         end
         error_in  = ERR_W'(sum);
         done      = (cur_x_in == goal_x_ff) && (cur_y_in == goal_y_ff);
         active_in = !done;
      end

      pixel.blank = (command == CMD_STEP) && !active_ff;
      pixel.x     = cur_x_in;
      pixel.y     = cur_y_in;
      pixel.color = color_in;
      pixel.done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         span_x_ff     <= '0;
         neg_span_y_ff <= '0;
         step_right_ff <= 1'b0;
         step_down_ff  <= 1'b0;
         error_ff      <= '0;
         color_ff      <= '0;
         active_ff     <= 1'b0;
      end else if (fire) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         span_x_ff     <= span_x_in;
         neg_span_y_ff <= neg_span_y_in;
         step_right_ff <= step_right_in;
         step_down_ff  <= step_down_in;
         error_ff      <= error_in;
         color_ff      <= color_in;
         active_ff     <= active_in;
      end
   end

   a_done_ends_line : assert property (@(posedge clock) disable iff (reset)
      (fire && pixel.done) |=> !active_ff)
      else $error("line still active after its last pixel");

   a_active_not_at_goal : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cur_x_ff != goal_x_ff || cur_y_ff != goal_y_ff))
      else $error("active line already at its endpoint");

   a_idle_step_keeps_state : assert property (@(posedge clock) disable iff (reset)
      (fire && pixel.blank) |=> ($stable(cur_x_ff) && $stable(cur_y_ff) && !active_ff))
      else $error("step while idle changed the line state");

endmodule

`default_nettype wire

### hw/rtl/clr_clip.sv
// ----------------------------------------------------------------------------
// clr_clip
// Clip a pixel to the strip and form its buffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_clip
   import clr_pkg::*;
(
   input  pixel_type                 pixel,
   output logic                      write_enable,
   output logic [ADDR_W-1:0]         write_address,
   output logic [COLOR_W-1:0]        write_color,
   output logic                      line_done
);

   localparam logic signed [COORD_W:0] WidthLimit = (COORD_W+1)'(DISPLAY_WIDTH);
   localparam logic signed [COORD_W:0] RowLimit   = (COORD_W+1)'(STRIP_ROWS);

   logic              on_strip;
   logic [PROD_W-1:0] product;

   always_comb begin
      on_strip = !pixel.blank
                 && !pixel.x[COORD_W-1] && ((COORD_W+1)'(pixel.x) < WidthLimit)
                 && !pixel.y[COORD_W-1] && ((COORD_W+1)'(pixel.y) < RowLimit);
      product = PROD_W'(unsigned'(pixel.y)) * PROD_W'(DISPLAY_WIDTH)
                + PROD_W'(unsigned'(pixel.x));
      write_enable  = on_strip;
      write_address = on_strip ? product[ADDR_W-1:0] : '0;
      write_color   = on_strip ? pixel.color : '0;
      line_done     = pixel.blank || pixel.done;
   end

endmodule

`default_nettype wire

### hw/rtl/clipped_line_rasterizer.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line generator clipped to a strip frame buffer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one command word: start (endpoints and colour) or
//   step. Every word yields exactly one rsp_ word: a pixel write (enable,
//   address, colour) and line_done, which marks the endpoint or an idle step.
//   A word accepted on req_ is held in the input register; the Bresenham
//   update and clipping run between it and the result register, which loads
//   once the result register is empty or its response is being taken.
//   Throughput is one word per cycle while rsp_ready stays high: the single
//   add-compare update of the error term and the constant-width address
//   multiply sit between the two registers.
//   When rsp_ready is low the result is held and the input register fills;
//   req_ready drops only once both are occupied, and returns in the cycle
//   the response is taken.
//   Synchronous reset empties both registers and leaves no line active.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_line_rasterizer
   import clr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_command,
   input  wire logic signed [COORD_W-1:0] req_start_x,
   input  wire logic signed [COORD_W-1:0] req_start_y,
   input  wire logic signed [COORD_W-1:0] req_end_x,
   input  wire logic signed [COORD_W-1:0] req_end_y,
   input  wire logic [COLOR_W-1:0]        req_pen_color,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_write_enable,
   output logic [ADDR_W-1:0]              rsp_write_address,
   output logic [COLOR_W-1:0]             rsp_write_color,
   output logic                           rsp_line_done
);

   logic                      in_valid_ff;
   logic                      command_ff;
   logic signed [COORD_W-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [COLOR_W-1:0]        color_ff;

   logic                      out_valid_ff;
   logic                      enable_ff, enable_in;
   logic [ADDR_W-1:0]         address_ff, address_in;
   logic [COLOR_W-1:0]        wcolor_ff, wcolor_in;
   logic                      done_ff, done_in;

   logic                      advance, fire, take;
   pixel_type                 pixel;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   clr_step u_step (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .command   (command_ff),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .end_x     (end_x_ff),
      .end_y     (end_y_ff),
      .pen_color (color_ff),
      .pixel     (pixel)
   );

   clr_clip u_clip (
      .pixel         (pixel),
      .write_enable  (enable_in),
      .write_address (address_in),
      .write_color   (wcolor_in),
      .line_done     (done_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         command_ff <= req_command;
         start_x_ff <= req_start_x;
         start_y_ff <= req_start_y;
         end_x_ff   <= req_end_x;
         end_y_ff   <= req_end_y;
         color_ff   <= req_pen_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         enable_ff  <= enable_in;
         address_ff <= address_in;
         wcolor_ff  <= wcolor_in;
         done_ff    <= done_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_enable  = enable_ff;
   assign rsp_write_address = address_ff;
   assign rsp_write_color   = wcolor_ff;
   assign rsp_line_done     = done_ff;

   a_held_word_kept : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(command_ff)))
      else $error("held command word lost while response stalled");

   a_response_has_source : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("response raised without a command word");

   a_stalled_result_held : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(address_ff)
                                        && $stable(done_ff)))
      else $error("stalled response changed");

endmodule

`default_nettype wire

### sim/tb_clipped_line_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_clipped_line_rasterizer
// Self-checking testbench for the clipped line rasteriser.
// Command words go in over req_ with random gaps. Each one is traced through
// a local Bresenham and clipping model into an expected pixel write. Every
// rsp_ word is compared field by field with the oldest pending write while
// the receiver stalls at random. Directed cases come first: idle steps,
// single-pixel lines, extreme endpoints and strip corners. Random lines
// mostly around the strip, with random colours follow.
// ----------------------------------------------------------------------------
module tb_clipped_line_rasterizer;
   import clr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 1900;
   localparam int TAIL_CYCLES    = 8;

   typedef struct packed {
      logic                enable;
      logic [ADDR_W-1:0]   address;
      logic [COLOR_W-1:0]  color;
      logic                done;
   } write_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_command = CMD_STEP;
   logic signed [COORD_W-1:0]   req_start_x = '0;
   logic signed [COORD_W-1:0]   req_start_y = '0;
   logic signed [COORD_W-1:0]   req_end_x = '0;
   logic signed [COORD_W-1:0]   req_end_y = '0;
   logic [COLOR_W-1:0]          req_pen_color = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_write_enable;
   logic [ADDR_W-1:0]           rsp_write_address;
   logic [COLOR_W-1:0]          rsp_write_color;
   logic                        rsp_line_done;

   // Local copy of the line state
   logic signed [COORD_W-1:0]   pen_x, pen_y, aim_x, aim_y;
   logic [SPAN_W-1:0]           run_x;
   logic signed [SPAN_W-1:0]    rise_neg;
   logic signed [ERR_W-1:0]     slack;
   logic                        go_right, go_down, drawing;
   logic [COLOR_W-1:0]          ink;

   write_word_type pending_writes[$];
   int             mismatches = 0;
   int             drawn_words = 0;
   int             stall_left = 0;
   int             silent_cycles = 0;
   bit             no_gaps = 1'b0;

   clipped_line_rasterizer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_pen_color     (req_pen_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_write_color   (rsp_write_color),
      .rsp_line_done     (rsp_line_done)
   );

   always #5 clock = ~clock;

   // Mostly back to back, now and then a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // Trace one accepted command word into the pixel write it must produce
   task automatic rasterise_word(input command_type cmd,
                                 input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                                 input logic [COLOR_W-1:0] color);
      int             x, y, dx, dy, err, twice;
      logic           done;
      write_word_type w;
      done = 1'b1;
      if (cmd == CMD_START) begin
         pen_x = sx;
         pen_y = sy;
         aim_x = ex;
         aim_y = ey;
         ink   = color;
         dx = int'(ex) - int'(sx);
         dy = int'(ey) - int'(sy);
         run_x    = SPAN_W'((dx < 0) ? -dx : dx);
         rise_neg = SPAN_W'((dy < 0) ? dy : -dy);
         go_right = sx < ex;
         go_down  = sy < ey;
         slack    = ERR_W'(int'(run_x) + int'(rise_neg));
         done     = (sx == ex) && (sy == ey);
         drawing  = !done;
      end else if (drawing) begin
         x     = pen_x;
         y     = pen_y;
         err   = slack;
         twice = 2 * err;
         if (twice >= int'(rise_neg)) begin
            err += int'(rise_neg);
            x   += go_right ? 1 : -1;
         end
         if (twice <= int'(run_x)) begin
            err += int'(run_x);
            y   += go_down ? 1 : -1;
         end
         pen_x = x[COORD_W-1:0];
         pen_y = y[COORD_W-1:0];
         slack = err[ERR_W-1:0];
         done  = (pen_x == aim_x) && (pen_y == aim_y);
         if (done) drawing = 1'b0;
      end
      w = '0;
      w.done = done;
      x = pen_x;
      y = pen_y;
      // Clip to the strip
      if (x >= 0 && x < DISPLAY_WIDTH && y >= 0 && y < STRIP_ROWS) begin
         w.enable  = 1'b1;
         x         = y * DISPLAY_WIDTH + x;
         w.address = x[ADDR_W-1:0];
         w.color   = ink;
      end
      pending_writes.push_back(w);
   endtask

   task automatic send_word(input command_type cmd, input int sx, sy, ex, ey,
                            input logic [COLOR_W-1:0] color);
      int                        gap;
      logic                      idle_step;
      logic signed [COORD_W-1:0] sx_w, sy_w, ex_w, ey_w;
      sx_w = COORD_W'(sx);
      sy_w = COORD_W'(sy);
      ex_w = COORD_W'(ex);
      ey_w = COORD_W'(ey);
      gap  = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_start_x   <= sx_w;
      req_start_y   <= sy_w;
      req_end_x     <= ex_w;
      req_end_y     <= ey_w;
      req_pen_color <= color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      drawn_words++;
      idle_step = (cmd == CMD_STEP) && !drawing;
      if (idle_step)
         pending_writes.push_back('{enable: 1'b0, address: '0, color: '0, done: 1'b1});
      else
         rasterise_word(cmd, sx_w, sy_w, ex_w, ey_w, color);
   endtask

   task automatic send_step();
      send_word(CMD_STEP, $urandom, $urandom, $urandom, $urandom, COLOR_W'($urandom));
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   task automatic test_idle_steps();
      send_step();
      send_step();
   endtask

   task automatic test_single_pixel();
      send_word(CMD_START, 0, 0, 0, 0, 16'hFFFF);
      send_step();
      send_word(CMD_START, -2048, -2048, -2048, -2048, 16'h1234);
   endtask

   // Full-range endpoints; each new start drops the line still running
   task automatic test_extreme_endpoints();
      send_word(CMD_START, -2048, -2048, 2047, 2047, 16'h0000);
      repeat (3) send_step();
      send_word(CMD_START, 2047, 2047, -2048, -2048, 16'hAAAA);
      repeat (2) send_step();
      send_word(CMD_START, 2047, -2048, -2048, 2047, 16'h5555);
      send_step();
   endtask

   // Lines that cross the strip corners, entering and leaving the buffer
   task automatic test_strip_corners();
      send_word(CMD_START, -1, -1, 1, 1, 16'hF800);
      repeat (2) send_step();
      send_word(CMD_START, DISPLAY_WIDTH - 1, STRIP_ROWS - 1,
                DISPLAY_WIDTH + 1, STRIP_ROWS + 1, 16'h07E0);
      repeat (2) send_step();
   endtask

   task automatic test_random_lines();
      int sx, sy, ex, ey, len, steps, r;
      while (drawn_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
         r  = $urandom_range(0, 99);
         sx = $urandom_range(0, DISPLAY_WIDTH + 31) - 16;
         sy = $urandom_range(0, STRIP_ROWS + 31) - 16;
         if (r < 60) begin
            ex = sx + $urandom_range(0, 80) - 40;
            ey = sy + $urandom_range(0, 80) - 40;
         end else if (r < 85) begin
            ex = sx + $urandom_range(0, 6) - 3;
            ey = sy + $urandom_range(0, 6) - 3;
         end else begin
            sx = $urandom_range(0, 4095) - 2048;
            sy = $urandom_range(0, 4095) - 2048;
            ex = $urandom_range(0, 4095) - 2048;
            ey = $urandom_range(0, 4095) - 2048;
         end
         len = (ex > sx) ? ex - sx : sx - ex;
         if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
         steps = len;
         r = $urandom_range(0, 99);
         // Cut short so the next start drops the line, or overrun into idle steps
         if (len > 64 || r < 15) steps = $urandom_range(0, (len > 8) ? 8 : len);
         else if (r < 35) steps = len + $urandom_range(1, 3);
         send_word(CMD_START, sx, sy, ex, ey, COLOR_W'($urandom_range(0, 65535)));
         repeat (steps) send_step();
      end
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      write_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            report_mismatch("unexpected word, line_done", int'(rsp_line_done), -1);
         end else begin
            w = pending_writes.pop_front();
            if (rsp_write_enable !== w.enable)
               report_mismatch("write_enable", int'(rsp_write_enable), int'(w.enable));
            if (rsp_write_address !== w.address)
               report_mismatch("write_address", int'(rsp_write_address),
                               int'(w.address));
            if (rsp_write_color !== w.color)
               report_mismatch("write_color", int'(rsp_write_color), int'(w.color));
            if (rsp_line_done !== w.done)
               report_mismatch("line_done", int'(rsp_line_done), int'(w.done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         silent_cycles = 0;
      end else begin
         silent_cycles++;
         if (silent_cycles >= WATCHDOG_LIMIT) begin
            $display("clipped_line_rasterizer regression: fail");
            $finish;
         end
      end
   end

   initial begin
      pen_x    = '0;
      pen_y    = '0;
      aim_x    = '0;
      aim_y    = '0;
      run_x    = '0;
      rise_neg = '0;
      slack    = '0;
      go_right = 1'b0;
      go_down  = 1'b0;
      drawing  = 1'b0;
      ink      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_steps();
      test_single_pixel();
      test_extreme_endpoints();
      test_strip_corners();
      test_random_lines();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("clipped_line_rasterizer regression: pass");
      else
         $display("clipped_line_rasterizer regression: fail");
      $finish;
   end

endmodule
